// ===== rtl/ctrf_pkg.sv =====
// Shared types and constants for the compare timer with rollover flags.
package ctrf_pkg;

	// Compare channels that really exist (1 to 3).
	localparam int CMP_CHANNELS = 3;
	localparam int CMP_IDX_W    = (CMP_CHANNELS > 1) ? $clog2(CMP_CHANNELS) : 1;

	localparam int CNT_W  = 32;
	localparam int PRE_W  = 12;
	localparam int FLAG_W = 4;
	// Status and enable layout: compare flags in the low bits, rollover on top.
	localparam int ROLL_BIT = 3;

	// Operation codes of an input item.
	localparam logic [1:0] OP_TICK  = 2'd0;
	localparam logic [1:0] OP_READ  = 2'd1;
	localparam logic [1:0] OP_WRITE = 2'd2;

	// Bus register selects.
	localparam logic [2:0] REG_STATUS = 3'd0;
	localparam logic [2:0] REG_IRQ_EN = 3'd1;
	localparam logic [2:0] REG_CMP1   = 3'd2;
	localparam logic [2:0] REG_CMP2   = 3'd3;
	localparam logic [2:0] REG_CMP3   = 3'd4;
	localparam logic [2:0] REG_COUNT  = 3'd5;

	// Configuration register indexes.
	localparam logic CFG_ENABLE   = 1'b0;
	localparam logic CFG_PRESCALE = 1'b1;

	typedef struct packed {
		logic [1:0]       op;
		logic [2:0]       reg_sel;
		logic [CNT_W-1:0] wdata;
	} in_item_t;

	typedef struct packed {
		logic [CNT_W-1:0] rdata;
		logic             irq;
	} out_item_t;

endpackage

// ===== rtl/compare_timer_with_rollover_flags.sv =====
// Top level: free-running 32-bit timer with output compare and rollover flags.

// Each item is one timer tick, one register read or one register write, and
// yields exactly one result item (read data, zero unless a read, and the irq
// level after the item's update). The block takes one item per cycle unless
// the result register is stalled: an item is applied to the timer state in the
// cycle it is accepted and its result lands in a single output register, valid
// in the next cycle. Input ready drops only while the output register holds
// a result that the consumer has not taken. The critical path is the 32-bit
// counter increment followed by the equality compare against the compare
// registers. Ticks advance the prescaler while enabled; every prescale+1 ticks
// the counter steps, a wrap to zero sets the rollover flag (bit 3), and landing
// on a compare value sets that channel's flag (bits 0..2). Writing a one to a
// status bit clears it. The counter is read only. Configuration (enable,
// prescale) is written through cfg_we/cfg_index/cfg_wdata with no wait.
module compare_timer_with_rollover_flags
	import ctrf_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [PRE_W-1:0] cfg_wdata
);

	// Configuration
	logic             enable_q;
	logic [PRE_W-1:0] prescale_q;

	// Timer state
	logic [CNT_W-1:0]  cnt_q;
	logic [PRE_W-1:0]  pcnt_q;
	logic [CNT_W-1:0]  cmp_q [CMP_CHANNELS];
	logic [FLAG_W-1:0] status_q;
	logic [FLAG_W-1:0] irq_en_q;

	// Result register
	logic      out_valid_q;
	out_item_t out_q;

	logic accept;

	// Next-state values for the accepted item
	logic [CNT_W-1:0]  cnt_inc;
	logic              step;
	logic              advance;
	logic [CNT_W-1:0]  cnt_d;
	logic [PRE_W-1:0]  pcnt_d;
	logic [FLAG_W-1:0] status_d;
	logic [FLAG_W-1:0] irq_en_d;
	logic [CNT_W-1:0]  rdata_d;
	logic [2:0]        cmp_off;
	logic              cmp_sel_ok;
	logic [CMP_IDX_W-1:0] cmp_idx;

	assign accept    = in_valid && in_ready;
	// Take a new item whenever the result register is free or draining.
	assign in_ready  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// Compare register addressing for reads and writes.
	assign cmp_off    = in_data.reg_sel - REG_CMP1;
	assign cmp_sel_ok = (in_data.reg_sel == REG_CMP1 || in_data.reg_sel == REG_CMP2 ||
		in_data.reg_sel == REG_CMP3) && (cmp_off < 3'(CMP_CHANNELS));
	assign cmp_idx    = cmp_off[CMP_IDX_W-1:0];

	assign cnt_inc = cnt_q + 1'b1;
	assign advance = (in_data.op == OP_TICK) && enable_q;
	// A prescaler at or past its limit completes a counter step on this tick.
	assign step    = advance && (pcnt_q >= prescale_q);

	always_comb begin
		cnt_d    = cnt_q;
		pcnt_d   = pcnt_q;
		status_d = status_q;
		irq_en_d = irq_en_q;
		rdata_d  = '0;
		case (in_data.op)
			OP_TICK: begin
				if (step) begin
					pcnt_d = '0;
					cnt_d  = cnt_inc;
					if (cnt_inc == '0) begin
						status_d[ROLL_BIT] = 1'b1;
					end
					for (int ch = 0; ch < CMP_CHANNELS; ch++) begin
						if (cnt_inc == cmp_q[ch]) begin
							status_d[ch] = 1'b1;
						end
					end
				end else if (advance) begin
					pcnt_d = pcnt_q + 1'b1;
				end
			end
			OP_READ: begin
				unique case (in_data.reg_sel)
					REG_STATUS: rdata_d = CNT_W'(status_q);
					REG_IRQ_EN: rdata_d = CNT_W'(irq_en_q);
					REG_CMP1, REG_CMP2, REG_CMP3: begin
						if (cmp_sel_ok) begin
							rdata_d = cmp_q[cmp_idx];
						end
					end
					REG_COUNT: rdata_d = cnt_q;
					default:   rdata_d = '0;
				endcase
			end
			OP_WRITE: begin
				unique case (in_data.reg_sel)
					REG_STATUS: status_d = status_q & ~in_data.wdata[FLAG_W-1:0];
					REG_IRQ_EN: irq_en_d = in_data.wdata[FLAG_W-1:0];
					default:    ;
				endcase
			end
			default: ;
		endcase
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q   <= 1'b0;
			prescale_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ENABLE:   enable_q   <= cfg_wdata[0];
				CFG_PRESCALE: prescale_q <= cfg_wdata;
				default:      ;
			endcase
		end
	end

	// Timer state: update only on an accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			pcnt_q   <= '0;
			status_q <= '0;
			irq_en_q <= '0;
			for (int ch = 0; ch < CMP_CHANNELS; ch++) begin
				cmp_q[ch] <= '1;
			end
		end else if (accept) begin
			cnt_q    <= cnt_d;
			pcnt_q   <= pcnt_d;
			status_q <= status_d;
			irq_en_q <= irq_en_d;
			if (in_data.op == OP_WRITE && cmp_sel_ok) begin
				cmp_q[cmp_idx] <= in_data.wdata;
			end
		end
	end

	// Result register: hold until taken, load on accept
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q.rdata <= rdata_d;
			out_q.irq   <= |(status_d & irq_en_d);
		end
	end

`ifndef ASSERT_OFF
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid_q |-> in_ready)
		else $error("input stalled with empty result register");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q)
		else $error("accepted item produced no result");

	a_rdata_zero: assert property (@(posedge clk) disable iff (!arst_n)
		accept && in_data.op != OP_READ |=> out_q.rdata == '0)
		else $error("nonzero read data on a non-read item");

	a_hold_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		!enable_q |=> cnt_q == $past(cnt_q) && pcnt_q == $past(pcnt_q))
		else $error("timer moved while disabled");

	a_rollover_flag: assert property (@(posedge clk) disable iff (!arst_n)
		accept && step && cnt_inc == '0 |=> status_q[ROLL_BIT])
		else $error("counter wrapped without rollover flag");
`endif

endmodule
